// ----- design/eerf_pkg.sv -----
// Shared types, constants and sequencer states for the equal error rate finder.
package eerf_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int RATE_W     = 17;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd1;
  localparam logic [1:0] STATUS_CLIPPED  = 2'd2;

  typedef struct packed {
    logic [31:0] true_pos;
    logic [31:0] true_neg;
    logic [31:0] false_pos;
    logic [31:0] false_neg;
    logic        last_matrix;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] eer_value;
    logic [1:0]        status;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_FP,
    ST_DIV_FP,
    ST_WR_FP,
    ST_DIV_FN,
    ST_WR_FN,
    ST_SORT_NEXT,
    ST_KEY_RD,
    ST_KEY_LD,
    ST_CMP_RD,
    ST_CMP,
    ST_PLACE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL_A,
    ST_MUL_B,
    ST_FIX,
    ST_DIV_EER,
    ST_RESULT
  } state_t;

endpackage

// ----- design/eerf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module eerf_ram #(
  parameter int W     = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/equal_error_rate_finder_top.sv -----
// Equal error rate finder: rate division, in-place sort, scan and interpolation.
// Each matrix takes two 17-step passes of the shared restoring divider.
// A last-marked matrix adds the insertion sort of both lists, a scan of the
// points and an interpolation.
// One matrix at a time; a result may wait in the output register while intake goes on.
// Synchronous active-low reset clears the sequencer, point count and output valid.
module equal_error_rate_finder_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  eerf_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output eerf_pkg::out_t out_data
);

  localparam int AW = eerf_pkg::ADDR_W;
  localparam int CW = eerf_pkg::CNT_W;
  localparam int RW = eerf_pkg::RATE_W;

  eerf_pkg::state_t state_r, state_nxt;

  eerf_pkg::in_t    item_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    j_r;
  logic             list_r;
  logic [RW-1:0]    key_r;
  logic [RW-1:0]    best_r;
  logic [RW-1:0]    ax_r, ay_r, bx_r, by_r;
  logic [33:0]      prod_r;
  logic [33:0]      acc_r;
  logic             out_valid_r;
  eerf_pkg::out_t   out_data_r;
  eerf_pkg::out_t   res_r;

  // shared divider
  logic [33:0]      div_rem_r;
  logic [32:0]      div_d_r;
  logic [16:0]      div_xlo_r;
  logic [16:0]      div_q_r;
  logic [4:0]       div_cnt_r;
  logic [33:0]      rem_sh;
  logic [34:0]      diff;
  logic             div_done;

  // rams
  logic             fp_we, fn_we;
  logic [AW-1:0]    waddr, raddr;
  logic [RW-1:0]    wdata;
  logic [RW-1:0]    fp_rdata, fn_rdata, sort_rdata;

  logic             in_fire;
  logic             sort_move;
  logic [RW-1:0]    sep;
  logic             scan_keep;
  logic [16:0]      mul_a, mul_b;
  logic [33:0]      mul_p;
  logic signed [34:0] num_raw, num_fix;
  logic signed [19:0] den_raw, den_fix;
  logic [18:0]      den_pos;
  logic             clip_hi;
  logic [RW-1:0]    rate_q;

  assign in_stall  = (state_r != eerf_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider step
  assign rem_sh   = {div_rem_r[32:0], div_xlo_r[16]};
  assign diff     = {1'b0, rem_sh} - {2'b00, div_d_r};
  assign div_done = (div_cnt_r == 5'd0);
  assign rate_q   = (div_d_r == 33'd0) ? '0 : div_q_r;

  assign sort_rdata = list_r ? fn_rdata : fp_rdata;
  assign sort_move  = list_r ? (sort_rdata < key_r) : (sort_rdata > key_r);

  assign sep       = (fp_rdata > fn_rdata) ? fp_rdata - fn_rdata : fn_rdata - fp_rdata;
  assign scan_keep = (fn_rdata >= fp_rdata) && (sep <= best_r);

  assign mul_a = (state_r == eerf_pkg::ST_MUL_A) ? ax_r : ay_r;
  assign mul_b = (state_r == eerf_pkg::ST_MUL_A) ? by_r : bx_r;
  assign mul_p = mul_a * mul_b;

  assign num_raw = $signed({1'b0, acc_r}) - $signed({1'b0, prod_r});
  assign den_raw = $signed({3'b000, ax_r}) - $signed({3'b000, ay_r})
                 - $signed({3'b000, bx_r}) + $signed({3'b000, by_r});
  assign den_fix = den_raw[19] ? -den_raw : den_raw;
  assign num_fix = den_raw[19] ? -num_raw : num_raw;
  assign den_pos = den_fix[18:0];
  assign clip_hi = {1'b0, num_fix[33:0]} > {den_pos, 16'h0000};

  eerf_ram #(.W(RW), .DEPTH(eerf_pkg::MAX_POINTS)) u_fpr_ram (
    .clk(clk), .we(fp_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(fp_rdata)
  );

  eerf_ram #(.W(RW), .DEPTH(eerf_pkg::MAX_POINTS)) u_fnr_ram (
    .clk(clk), .we(fn_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(fn_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eerf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (count_r < CW'(eerf_pkg::MAX_POINTS)) begin
            state_nxt = eerf_pkg::ST_LD_FP;
          end else if (in_data.last_matrix) begin
            state_nxt = eerf_pkg::ST_SORT_NEXT;
          end
        end
      end
      eerf_pkg::ST_LD_FP:  state_nxt = eerf_pkg::ST_DIV_FP;
      eerf_pkg::ST_DIV_FP: if (div_done) state_nxt = eerf_pkg::ST_WR_FP;
      eerf_pkg::ST_WR_FP:  state_nxt = eerf_pkg::ST_DIV_FN;
      eerf_pkg::ST_DIV_FN: if (div_done) state_nxt = eerf_pkg::ST_WR_FN;
      eerf_pkg::ST_WR_FN: begin
        state_nxt = item_r.last_matrix ? eerf_pkg::ST_SORT_NEXT : eerf_pkg::ST_IDLE;
      end
      eerf_pkg::ST_SORT_NEXT: begin
        if (idx_r < count_r) begin
          state_nxt = eerf_pkg::ST_KEY_RD;
        end else if (list_r) begin
          state_nxt = eerf_pkg::ST_SCAN_RD;
        end
      end
      eerf_pkg::ST_KEY_RD: state_nxt = eerf_pkg::ST_KEY_LD;
      eerf_pkg::ST_KEY_LD: state_nxt = eerf_pkg::ST_CMP_RD;
      eerf_pkg::ST_CMP_RD: begin
        state_nxt = (j_r == '0) ? eerf_pkg::ST_PLACE : eerf_pkg::ST_CMP;
      end
      eerf_pkg::ST_CMP: begin
        state_nxt = sort_move ? eerf_pkg::ST_CMP_RD : eerf_pkg::ST_PLACE;
      end
      eerf_pkg::ST_PLACE: state_nxt = eerf_pkg::ST_SORT_NEXT;
      eerf_pkg::ST_SCAN_RD: begin
        state_nxt = (idx_r < count_r) ? eerf_pkg::ST_SCAN_CHK : eerf_pkg::ST_MUL_A;
      end
      eerf_pkg::ST_SCAN_CHK: begin
        state_nxt = scan_keep ? eerf_pkg::ST_SCAN_RD : eerf_pkg::ST_MUL_A;
      end
      eerf_pkg::ST_MUL_A: state_nxt = eerf_pkg::ST_MUL_B;
      eerf_pkg::ST_MUL_B: state_nxt = eerf_pkg::ST_FIX;
      eerf_pkg::ST_FIX: begin
        if (den_raw == '0 || num_fix < 0 || clip_hi) begin
          state_nxt = eerf_pkg::ST_RESULT;
        end else begin
          state_nxt = eerf_pkg::ST_DIV_EER;
        end
      end
      eerf_pkg::ST_DIV_EER: if (div_done) state_nxt = eerf_pkg::ST_RESULT;
      eerf_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) state_nxt = eerf_pkg::ST_IDLE;
      end
      default: state_nxt = eerf_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    fp_we = 1'b0;
    fn_we = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = rate_q;
    raddr = idx_r[AW-1:0];
    case (state_r)
      eerf_pkg::ST_WR_FP: fp_we = 1'b1;
      eerf_pkg::ST_WR_FN: fn_we = 1'b1;
      eerf_pkg::ST_CMP_RD: begin
        raddr = AW'(j_r - CW'(1));
      end
      eerf_pkg::ST_CMP: begin
        waddr = j_r[AW-1:0];
        wdata = sort_rdata;
        fp_we = sort_move && !list_r;
        fn_we = sort_move && list_r;
      end
      eerf_pkg::ST_PLACE: begin
        waddr = j_r[AW-1:0];
        wdata = key_r;
        fp_we = !list_r;
        fn_we = list_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eerf_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == eerf_pkg::ST_WR_FN) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == eerf_pkg::ST_RESULT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == eerf_pkg::ST_DIV_FP || state_r == eerf_pkg::ST_DIV_FN ||
        state_r == eerf_pkg::ST_DIV_EER) begin
      div_xlo_r <= {div_xlo_r[15:0], 1'b0};
      div_cnt_r <= div_cnt_r - 5'd1;
      if (!diff[34]) begin
        div_rem_r <= diff[33:0];
        div_q_r   <= {div_q_r[15:0], 1'b1};
      end else begin
        div_rem_r <= rem_sh;
        div_q_r   <= {div_q_r[15:0], 1'b0};
      end
    end
    case (state_r)
      eerf_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_r <= in_data;
          idx_r  <= CW'(1);
          list_r <= 1'b0;
        end
      end
      eerf_pkg::ST_LD_FP: begin
        div_rem_r <= {3'b000, item_r.false_pos[31:1]};
        div_xlo_r <= {item_r.false_pos[0], 16'h0000};
        div_d_r   <= {1'b0, item_r.false_pos} + {1'b0, item_r.true_neg};
        div_cnt_r <= 5'd16;
      end
      eerf_pkg::ST_WR_FP: begin
        div_rem_r <= {3'b000, item_r.false_neg[31:1]};
        div_xlo_r <= {item_r.false_neg[0], 16'h0000};
        div_d_r   <= {1'b0, item_r.false_neg} + {1'b0, item_r.true_pos};
        div_cnt_r <= 5'd16;
      end
      eerf_pkg::ST_WR_FN: begin
        idx_r  <= CW'(1);
        list_r <= 1'b0;
      end
      eerf_pkg::ST_SORT_NEXT: begin
        if (!(idx_r < count_r)) begin
          if (!list_r) begin
            list_r <= 1'b1;
            idx_r  <= CW'(1);
          end else begin
            idx_r  <= '0;
            best_r <= '1;
            ax_r   <= '0;
            ay_r   <= '0;
            bx_r   <= '0;
            by_r   <= '0;
          end
        end
      end
      eerf_pkg::ST_KEY_LD: begin
        key_r <= sort_rdata;
        j_r   <= idx_r;
      end
      eerf_pkg::ST_CMP: begin
        if (sort_move) j_r <= j_r - CW'(1);
      end
      eerf_pkg::ST_PLACE: idx_r <= idx_r + CW'(1);
      eerf_pkg::ST_SCAN_CHK: begin
        if (scan_keep) begin
          best_r <= sep;
          ax_r   <= fp_rdata;
          ay_r   <= fn_rdata;
          idx_r  <= idx_r + CW'(1);
        end else begin
          bx_r <= fp_rdata;
          by_r <= fn_rdata;
        end
      end
      eerf_pkg::ST_MUL_A: prod_r <= mul_p;
      eerf_pkg::ST_MUL_B: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      eerf_pkg::ST_FIX: begin
        div_rem_r <= {17'h0_0000, num_fix[33:17]};
        div_xlo_r <= num_fix[16:0];
        div_d_r   <= {14'h0000, den_pos};
        div_cnt_r <= 5'd16;
        if (den_raw == '0) begin
          res_r.eer_value <= '0;
          res_r.status    <= eerf_pkg::STATUS_ZERO_DIV;
        end else if (num_fix < 0) begin
          res_r.eer_value <= '0;
          res_r.status    <= eerf_pkg::STATUS_CLIPPED;
        end else if (clip_hi) begin
          res_r.eer_value <= RW'(65536);
          res_r.status    <= eerf_pkg::STATUS_CLIPPED;
        end
      end
      eerf_pkg::ST_DIV_EER: begin
        if (div_done) begin
          res_r.eer_value <= (!diff[34]) ? {div_q_r[15:0], 1'b1} : {div_q_r[15:0], 1'b0};
          res_r.status    <= eerf_pkg::STATUS_OK;
        end
      end
      // load the output register only when it is empty or its result is being taken
      eerf_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

endmodule
